// ===== hdl/fraction_arith_unit_assert.svh =====
// Assertion macros shared by the fraction arithmetic unit modules.
// No dependencies.
`ifndef FRACTION_ARITH_UNIT_ASSERT_SVH
`define FRACTION_ARITH_UNIT_ASSERT_SVH

// Implication checked every clock, disabled in reset.
`define FAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled in reset.
`define FAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/fau_pkg.sv =====
// Package for the fraction arithmetic unit: widths, operation codes and
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package fau_pkg;
  localparam int OPW  = 16;
  localparam int RAWW = 64;
  localparam int NUMW = 33;
  localparam int DENW = 31;
  localparam int CNTW = 7;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef struct packed {
    logic load;      // capture operands
    logic prod;      // form products
    logic sum;       // raw n, d; magnitudes
    logic div_start; // start a division step sequence
    logic div_step;  // one restoring step
    logic gcd_swap;  // x <= y, y <= remainder
    logic red_n;     // n/g start
    logic red_n_done;
    logic red_d_done;
    logic finish;    // build result
  } fau_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic y_zero;
    logic div_last;
  } fau_sts_t;
endpackage

// ===== hdl/fau_datapath.sv =====
// Datapath: products, raw numerator/denominator, shared restoring divider
// for Euclid remainders and the reduction. Depends on fau_pkg.
`timescale 1ns / 1ps
module fau_datapath (
  input  logic                          clk,
  input  fau_pkg::fau_cmd_t             cmd,
  output fau_pkg::fau_sts_t             sts,
  input  logic [1:0]                    in_action,
  input  logic signed [fau_pkg::OPW-1:0] in_a_num,
  input  logic signed [fau_pkg::OPW-1:0] in_a_den,
  input  logic signed [fau_pkg::OPW-1:0] in_b_num,
  input  logic signed [fau_pkg::OPW-1:0] in_b_den,
  output logic signed [fau_pkg::NUMW-1:0] res_num,
  output logic [fau_pkg::DENW-1:0]      res_den,
  output logic                          res_dz
);
  import fau_pkg::*;
  `include "fraction_arith_unit_assert.svh"

  logic [1:0] act_r;
  logic signed [OPW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [2*OPW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [RAWW-1:0] nm_r, dm_r, x_r, y_r, q_r, rem_r, dvd_r, dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic neg_r;
  logic [RAWW-1:0] qn_r;

  logic [RAWW-1:0] n_raw, d_raw, rem_sh, rem_sub;
  logic [RAWW:0] trial;

  always_comb begin
    unique case (action_t'(act_r))
      ACT_ADD: n_raw = RAWW'(p0_r) + RAWW'(p1_r);
      ACT_SUB: n_raw = RAWW'(p0_r) - RAWW'(p1_r);
      ACT_MUL: n_raw = RAWW'(p2_r);
      default: n_raw = RAWW'(p0_r);
    endcase
    d_raw = RAWW'(p3_r);
    rem_sh = {rem_r[RAWW-2:0], dvd_r[RAWW-1]};
    trial = {1'b0, rem_sh} - {1'b0, dvs_r};
    rem_sub = trial[RAWW] ? rem_sh : trial[RAWW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      an_r <= in_a_num; ad_r <= in_a_den; bn_r <= in_b_num; bd_r <= in_b_den;
    end
    if (cmd.prod) begin
      p0_r <= an_r * bd_r;
      p1_r <= ad_r * bn_r;
      p2_r <= an_r * bn_r;
      p3_r <= (act_r == ACT_DIV) ? ad_r * bn_r : ad_r * bd_r;
    end
    if (cmd.sum) begin
      nm_r <= n_raw[RAWW-1] ? -n_raw : n_raw;
      dm_r <= d_raw[RAWW-1] ? -d_raw : d_raw;
      x_r  <= n_raw[RAWW-1] ? -n_raw : n_raw;
      y_r  <= d_raw[RAWW-1] ? -d_raw : d_raw;
      neg_r <= n_raw[RAWW-1] ^ d_raw[RAWW-1];
    end
    if (cmd.div_start) begin
      // gcd remainder x%y, or reduction (nm or dm) / x
      dvd_r <= cmd.red_n ? nm_r : (cmd.red_n_done ? dm_r : x_r);
      dvs_r <= (cmd.red_n || cmd.red_n_done) ? x_r : y_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_sub;
      dvd_r <= {dvd_r[RAWW-2:0], ~trial[RAWW]};
      cnt_r <= cnt_r + CNTW'(1);
    end
    if (cmd.gcd_swap) begin
      x_r <= y_r;
      y_r <= rem_r;
    end
    if (cmd.red_d_done) q_r <= dvd_r;
    if (cmd.red_n_done && !cmd.div_start) qn_r <= dvd_r;
    if (cmd.red_n_done && cmd.div_start) qn_r <= dvd_r;
  end

  assign sts.d_zero   = (p3_r == '0);
  assign sts.y_zero   = (y_r == '0);
  assign sts.div_last = (cnt_r == CNTW'(RAWW-1));

  always_comb begin
    if (sts.d_zero) begin
      res_num = '0; res_den = DENW'(1); res_dz = 1'b1;
    end else begin
      res_num = (neg_r && qn_r != '0) ? -NUMW'(qn_r) : NUMW'(qn_r);
      res_den = DENW'(q_r);
      res_dz = 1'b0;
    end
  end
endmodule

// ===== hdl/fau_ctrl.sv =====
// Controller state machine sequencing operand capture, Euclid loop and
// reduction divides. Depends on fau_pkg and the assertion header.
`timescale 1ns / 1ps
module fau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fau_pkg::fau_cmd_t cmd,
  input  fau_pkg::fau_sts_t sts
);
  import fau_pkg::*;
  `include "fraction_arith_unit_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PROD  = 10'b0000000010,
    S_SUM   = 10'b0000000100,
    S_GTEST = 10'b0000001000,
    S_GDIV  = 10'b0000010000,
    S_NDIV  = 10'b0000100000,
    S_DDIV  = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_CHK   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  // The denominator quotient lands in the cycle after the last step.
  logic fin_d_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_PROD;
      end
      S_PROD: begin cmd.prod = 1'b1; state_nxt = S_CHK; end
      S_CHK: begin
        cmd.sum = 1'b1;
        state_nxt = sts.d_zero ? S_OUT : S_GTEST;
      end
      S_GTEST: begin
        if (sts.y_zero) begin
          cmd.div_start = 1'b1; cmd.red_n = 1'b1; state_nxt = S_NDIV;
        end else begin
          cmd.div_start = 1'b1; state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SUM;
      end
      S_SUM: begin cmd.gcd_swap = 1'b1; state_nxt = S_GTEST; end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.red_n_done = 1'b1; cmd.div_start = 1'b1; state_nxt = S_DDIV;
      end
      S_DDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin cmd.finish = 1'b1; state_nxt = S_OUT; end
      end
      S_OUT: begin
        cmd.red_d_done = fin_d_r;
        if (out_ready && !fin_d_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_d_r <= 1'b0;
    else fin_d_r <= cmd.finish;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT) && !fin_d_r;

  `FAU_ASSERT_IMP(a_one_side, clk, rst_n, 1'b1, !(in_ready && out_valid))
  `FAU_ASSERT_NXT(a_take, clk, rst_n, in_valid && in_ready, state_r == S_PROD)
  `FAU_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

// ===== hdl/fraction_arith_unit.sv =====
// Top level of the fraction arithmetic unit: controller plus datapath.
// Depends on fau_pkg, fau_ctrl, fau_datapath.
//
// Usage: the input channel (in_valid/in_ready) carries an operation and two
// signed 16-bit fractions; the result channel (out_valid/out_ready) returns
// the reduced fraction with a positive denominator and a div_zero flag.
// One item is in flight at a time. After the input transfer come the products
// and raw sums, then per Euclid remainder a test state, 64 steps of one
// 64-bit restoring divider and a swap state, then the two reductions by the
// gcd, then a registered finish flag lets the last quotient settle before
// out_valid rises.
// A zero raw denominator skips the loop: out_valid rises after the product
// and check states with 0/1 and div_zero. in_ready is high only while idle,
// so the next transfer comes at the earliest in the cycle after the result.
// Reset (rst_n low, synchronous) returns the controller to idle with no
// result pending. If the receiver stalls, the result holds on the output
// ports until the transfer completes; no new item is taken meanwhile.
`timescale 1ns / 1ps
module fraction_arith_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic signed [fau_pkg::OPW-1:0] in_a_num,
  input  logic signed [fau_pkg::OPW-1:0] in_a_den,
  input  logic signed [fau_pkg::OPW-1:0] in_b_num,
  input  logic signed [fau_pkg::OPW-1:0] in_b_den,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [fau_pkg::NUMW-1:0] out_res_num,
  output logic [fau_pkg::DENW-1:0]      out_res_den,
  output logic                          out_div_zero
);
  import fau_pkg::*;

  fau_cmd_t cmd;
  fau_sts_t sts;

  fau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  fau_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .in_action(in_action),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num),
    .in_b_den(in_b_den), .res_num(out_res_num), .res_den(out_res_den),
    .res_dz(out_div_zero)
  );
endmodule

// ===== tb/tb.sv =====
// Testbench for fraction_arith_unit: directed table then random fractions, checked
// against an in-bench rational predictor. Depends on fau_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import fau_pkg::*;

  typedef struct {
    action_t act;
    logic signed [OPW-1:0] an, ad, bn, bd;
    bit has_exp;
    logic signed [NUMW-1:0] e_num;
    logic [DENW-1:0] e_den;
    logic e_dz;
  } frac_row_t;

  typedef struct {
    logic signed [NUMW-1:0] num;
    logic [DENW-1:0] den;
    logic dz;
  } frac_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic signed [OPW-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [NUMW-1:0] out_res_num;
  logic [DENW-1:0] out_res_den;
  logic out_div_zero;

  frac_res_t exp_q[$];
  int mismatches = 0;
  int n_results = 0;
  int n_dz = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  fraction_arith_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_num(out_res_num), .out_res_den(out_res_den), .out_div_zero(out_div_zero)
  );

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(action_t act, logic signed [OPW-1:0] an,
      logic signed [OPW-1:0] ad, logic signed [OPW-1:0] bn, logic signed [OPW-1:0] bd);
    logic signed [63:0] xan, xad, xbn, xbd, n, d;
    logic [63:0] nm, dm, g;
    frac_res_t r;
    xan = an; xad = ad; xbn = bn; xbd = bd;
    case (act)
      ACT_ADD: begin n = xan * xbd + xad * xbn; d = xad * xbd; end
      ACT_SUB: begin n = xan * xbd - xad * xbn; d = xad * xbd; end
      ACT_MUL: begin n = xan * xbn; d = xad * xbd; end
      default: begin n = xan * xbd; d = xad * xbn; end
    endcase
    if (d == 0) begin
      r.num = '0; r.den = DENW'(1); r.dz = 1'b1;
      return r;
    end
    nm = n[63] ? -n : n;
    dm = d[63] ? -d : d;
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    r.num = NUMW'(((n[63] != d[63]) && nm != 0) ? -nm : nm);
    r.den = dm[DENW-1:0];
    r.dz = 1'b0;
    return r;
  endfunction

  // leaves in_valid high; the caller drops it before any gap
  task automatic send_fraction(frac_row_t row);
    frac_res_t e;
    e = reduce_fraction(row.act, row.an, row.ad, row.bn, row.bd);
    if (row.has_exp) begin
      // typed-in value must agree with the predictor too
      if (e.num != row.e_num || e.den != row.e_den || e.dz != row.e_dz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row disagrees with predictor: exp %0d/%0d dz %0b got %0d/%0d dz %0b",
                   row.e_num, row.e_den, row.e_dz, e.num, e.den, e.dz);
      end
      e.num = row.e_num; e.den = row.e_den; e.dz = row.e_dz;
    end
    in_valid <= 1;
    in_action <= row.act;
    in_a_num <= row.an; in_a_den <= row.ad; in_b_num <= row.bn; in_b_den <= row.bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_q.push_back(e);
  endtask

  function automatic logic signed [OPW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return OPW'($urandom_range(0, 20) - 10);
      3: return OPW'($urandom_range(0, 400) - 200);
      default: return OPW'($urandom);
    endcase
  endfunction

  function automatic frac_row_t mk(action_t act, int an, int ad, int bn, int bd);
    frac_row_t r;
    r.act = act; r.an = OPW'(an); r.ad = OPW'(ad); r.bn = OPW'(bn); r.bd = OPW'(bd);
    r.has_exp = 1'b0;
    r.e_num = '0; r.e_den = '0; r.e_dz = 1'b0;
    return r;
  endfunction

  function automatic frac_row_t mke(action_t act, int an, int ad, int bn, int bd,
      longint en, longint ed, bit dz);
    frac_row_t r;
    r = mk(act, an, ad, bn, bd);
    r.has_exp = 1'b1; r.e_num = NUMW'(en); r.e_den = DENW'(ed); r.e_dz = dz;
    return r;
  endfunction

  // result side: check and stall pattern
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_div_zero) n_dz++;
        if (exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %0d/%0d",
                                         out_res_num, out_res_den);
        end else begin
          e = exp_q.pop_front();
          if (e.num !== out_res_num || e.den !== out_res_den || e.dz !== out_div_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0d dz %0b, got %0d/%0d dz %0b",
                       e.num, e.den, e.dz, out_res_num, out_res_den, out_div_zero);
          end
        end
      end
      if (hold_off) out_ready <= 0;
      else if (n_results % 50 < 10) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    frac_row_t dir[$];
    frac_row_t row;
    int burst;
    dir.push_back(mke(ACT_ADD, 1, 2, 1, 3, 5, 6, 0));
    dir.push_back(mke(ACT_SUB, 1, 2, 1, 2, 0, 1, 0));
    dir.push_back(mke(ACT_MUL, 2, 3, 3, 4, 1, 2, 0));
    dir.push_back(mke(ACT_DIV, 1, 2, 1, 4, 2, 1, 0));
    dir.push_back(mke(ACT_ADD, 1, 0, 1, 1, 0, 1, 1));
    dir.push_back(mke(ACT_MUL, 1, 1, 1, 0, 0, 1, 1));
    dir.push_back(mke(ACT_DIV, 3, 4, 0, 5, 0, 1, 1));
    dir.push_back(mke(ACT_MUL, 0, 7, 5, 3, 0, 1, 0));
    dir.push_back(mke(ACT_MUL, 1, -2, 1, 1, -1, 2, 0));
    dir.push_back(mke(ACT_MUL, -1, -2, 1, 1, 1, 2, 0));
    dir.push_back(mke(ACT_MUL, -32768, 1, -32768, 1, 1073741824, 1, 0));
    dir.push_back(mke(ACT_MUL, 1, -32768, 1, -32768, 1, 1073741824, 0));
    dir.push_back(mke(ACT_ADD, -32768, 1, -32768, 1, -65536, 1, 0));
    dir.push_back(mke(ACT_SUB, 32767, 1, -32768, 1, 65535, 1, 0));
    dir.push_back(mk(ACT_ADD, 32767, -32768, -32768, 32767));
    dir.push_back(mk(ACT_SUB, -32768, 32767, 32767, -32768));
    dir.push_back(mk(ACT_DIV, -32768, 32767, -32768, 32767));
    dir.push_back(mk(ACT_DIV, 32767, -32768, -1, -1));
    dir.push_back(mk(ACT_ADD, 12345, -678, -9, 10));
    dir.push_back(mk(ACT_MUL, 21845, -21846, -21846, 21845));
    dir.push_back(mk(ACT_DIV, -1, 32767, 32767, 1));
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir[i]) send_fraction(dir[i]);
    // random part: bursts and gaps
    for (int i = 0; i < 400;) begin
      burst = $urandom_range(1, 8);
      for (int j = 0; j < burst && i < 400; j++, i++) begin
        row = mk(action_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                 rand_operand(), rand_operand());
        if ($urandom_range(0, 15) == 0) row.bd = '0;
        send_fraction(row);
        if (i == 100) begin
          // drain fully before going on
          in_valid <= 0;
          while (exp_q.size() != 0) @(posedge clk);
        end
        if (i == 200) begin
          hold_off = 1;
          fork
            begin
              repeat (600) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
      end
      if ($urandom_range(0, 1)) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 200)) @(posedge clk);
      end
    end
    in_valid <= 0;
    stim_done = 1;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d results (%0d with zero denominator), directed extremes and random.",
             n_results, n_dz);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout with %0d results pending", exp_q.size());
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/fau_pkg.sv
hdl/fau_datapath.sv
hdl/fau_ctrl.sv
hdl/fraction_arith_unit.sv
tb/tb.sv
